FILE: sv/ds_twr_distance_defines.svh
// assertion helpers used by the checker file
`ifndef DS_TWR_DISTANCE_DEFINES_SVH
`define DS_TWR_DISTANCE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define DSD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dsd check failed");

// next-cycle implication, clocked on clk, off during reset
`define DSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dsd check failed");

`endif

FILE: sv/dsd_pkg.sv
`timescale 1ns / 1ps
package dsd_pkg;
	localparam int TIME_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int STAMP_W       = 32;
	localparam int REG_W         = 24;
	localparam int SCALE_Q       = 16;
	localparam int STATUS_W      = 2;
	localparam int CFG_IDX_W     = 2;

	localparam logic [REG_W-1:0] MM_PER_TICK_RST = REG_W'(307392);
	localparam logic [REG_W-1:0] MAX_DIST_RST    = REG_W'(100000);

	localparam logic [CFG_IDX_W-1:0] REG_MM_PER_TICK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST    = 2'd1;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

	typedef struct packed {
		logic valid;
		logic bad;
	} dsd_ctl_t;
endpackage

FILE: sv/dsd_front.sv
`timescale 1ns / 1ps
module dsd_front import dsd_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [STAMP_W-1:0]     tag_poll_tx,
	input  logic [STAMP_W-1:0]     tag_resp_rx,
	input  logic [STAMP_W-1:0]     tag_final_tx,
	input  logic [STAMP_W-1:0]     own_poll_rx,
	input  logic [STAMP_W-1:0]     own_resp_tx,
	input  logic [STAMP_W-1:0]     own_final_rx,
	output dsd_ctl_t               ctl,
	output logic [TIME_BITS+1:0]   rem_init,
	output logic [TIME_BITS+1:0]   den,
	output logic [TIME_BITS-1:0]   num_low
);
	localparam int T  = TIME_BITS;
	localparam int RW = T + 2;

	logic          vld_s1, vld_s2, vld_s3;
	logic [T-1:0]  ra_s1, rb_s1, da_s1, db_s1;
	logic [2*T-1:0] pa_s2, pb_s2, num_s3;
	logic [RW-1:0] den_s2, den_s3;
	logic          bad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// reply and turnaround intervals, wrapping
			ra_s1  <= T'(tag_resp_rx) - T'(tag_poll_tx);
			rb_s1  <= T'(own_final_rx) - T'(own_resp_tx);
			da_s1  <= T'(tag_final_tx) - T'(tag_resp_rx);
			db_s1  <= T'(own_resp_tx) - T'(own_poll_rx);
			pa_s2  <= (2*T)'(ra_s1) * (2*T)'(rb_s1);
			pb_s2  <= (2*T)'(da_s1) * (2*T)'(db_s1);
			den_s2 <= RW'(ra_s1) + RW'(rb_s1) + RW'(da_s1) + RW'(db_s1);
			num_s3 <= pa_s2 - pb_s2;
			bad_s3 <= (pa_s2 <= pb_s2) || (den_s2 == '0);
			den_s3 <= den_s2;
		end
	end

	assign ctl.valid = vld_s3;
	assign ctl.bad   = bad_s3;
	assign rem_init  = RW'(num_s3[2*T-1:T]);
	assign den       = den_s3;
	assign num_low   = num_s3[T-1:0];
endmodule

FILE: sv/dsd_div_cell.sv
`timescale 1ns / 1ps
module dsd_div_cell import dsd_pkg::*; #(
	parameter int RW = TIME_BITS_DEF + 2,
	parameter int QW = TIME_BITS_DEF + FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  dsd_ctl_t      ctl_in,
	input  logic [RW-1:0] rem_in,
	input  logic [QW-1:0] low_in,
	input  logic [RW-1:0] den_in,
	output dsd_ctl_t      ctl_q,
	output logic [RW-1:0] rem_q,
	output logic [QW-1:0] low_q,
	output logic [RW-1:0] den_q
);
	logic [RW:0] trial, diff;
	logic        fit;

	// one restoring step: dividend bits leave the top, quotient bits enter below
	assign trial = {rem_in, low_in[QW-1]};
	assign fit   = trial >= {1'b0, den_in};
	assign diff  = trial - {1'b0, den_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fit ? diff[RW-1:0] : trial[RW-1:0];
			low_q <= {low_in[QW-2:0], fit};
			den_q <= den_in;
		end
	end
endmodule

FILE: sv/dsd_back.sv
`timescale 1ns / 1ps
module dsd_back import dsd_pkg::*; #(
	parameter int QW        = TIME_BITS_DEF + FRAC_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  dsd_ctl_t            ctl_in,
	input  logic [QW-1:0]       quot,
	input  logic [REG_W-1:0]    mm_per_tick_q16,
	input  logic [REG_W-1:0]    max_distance_mm,
	output logic                out_valid,
	output logic [REG_W-1:0]    distance_mm,
	output logic [STATUS_W-1:0] status
);
	localparam int QL = (QW + 1) / 2;
	localparam int QH = QW - QL;
	localparam int PW = QW + REG_W;
	localparam int SB = FRAC_BITS + SCALE_Q;
	localparam int LW = REG_W + SB;

	dsd_ctl_t          ctl_s1, ctl_s2;
	logic [QL+REG_W-1:0] pl_s1;
	logic [QH+REG_W-1:0] ph_s1;
	logic [PW-1:0]     prod_s2;
	logic [LW-1:0]     limit;
	logic [PW:0]       rnd;
	logic              vld_q;
	logic [REG_W-1:0]  dist_q;
	logic [STATUS_W-1:0] status_q;

	assign limit = {max_distance_mm, SB'(0)};
	assign rnd   = {1'b0, prod_s2} + ((PW+1)'(1) << (SB - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			vld_q  <= 1'b0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			vld_q  <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1   <= (QL+REG_W)'(quot[QL-1:0]) * (QL+REG_W)'(mm_per_tick_q16);
			ph_s1   <= (QH+REG_W)'(quot[QW-1:QL]) * (QH+REG_W)'(mm_per_tick_q16);
			prod_s2 <= (PW'(ph_s1) << QL) + PW'(pl_s1);
			if (ctl_s2.bad || prod_s2 == '0) begin
				dist_q   <= '0;
				status_q <= ST_REJECT;
			end else if (prod_s2 >= PW'(limit)) begin
				dist_q   <= '0;
				status_q <= ST_RANGE;
			end else begin
				dist_q   <= rnd[SB +: REG_W];
				status_q <= ST_OK;
			end
		end
	end

	assign out_valid   = vld_q;
	assign distance_mm = dist_q;
	assign status      = status_q;
endmodule

FILE: sv/ds_twr_distance.sv
`timescale 1ns / 1ps
// Asymmetric double-sided two-way ranging distance. Each input beat carries the six
// timestamps of one exchange; the block forms the four wrapping intervals, the time of
// flight (Ra*Rb - Da*Db)/(Ra+Rb+Da+Db) with FRAC_BITS fraction bits, scales it by
// mm_per_tick_q16 and rounds half up to millimetres. One result beat per input beat,
// status 0 accepted, 1 non-positive numerator, zero denominator or zero scaled product,
// 2 at or beyond max_distance_mm (distance_mm is zero whenever status is not 0). The
// block takes one beat per cycle while the output is not stalled. Its stages are three
// front stages (intervals, two products, numerator), one restoring divider cell per
// quotient bit, and three back stages (partial products, sum, range check and rounding).
// The whole pipe advances together, so a stalled output holds every stage and drops
// in_ready. Configuration writes through cfg_we/cfg_index/cfg_data take effect at once;
// an index beyond the register list is ignored.
module ds_twr_distance import dsd_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [STAMP_W-1:0]   tag_poll_tx,
	input  logic [STAMP_W-1:0]   tag_resp_rx,
	input  logic [STAMP_W-1:0]   tag_final_tx,
	input  logic [STAMP_W-1:0]   own_poll_rx,
	input  logic [STAMP_W-1:0]   own_resp_tx,
	input  logic [STAMP_W-1:0]   own_final_rx,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [REG_W-1:0]     distance_mm,
	output logic [STATUS_W-1:0]  status
);
	localparam int RW = TIME_BITS + 2;
	// quotient stays below 2^(TIME_BITS+FRAC_BITS) since Ra*Rb <= den^2/4
	localparam int QW = TIME_BITS + FRAC_BITS;

	logic             en;
	logic [REG_W-1:0] mm_q, maxd_q;

	// cell chain lanes: index 0 feeds the first cell
	dsd_ctl_t      ctl_c [0:QW];
	logic [RW-1:0] rem_c [0:QW];
	logic [QW-1:0] low_c [0:QW];
	logic [RW-1:0] den_c [0:QW];
	logic [TIME_BITS-1:0] num_low;

	// the pipe moves whenever the output register is free or being drained
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_q   <= MM_PER_TICK_RST;
			maxd_q <= MAX_DIST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MM_PER_TICK: mm_q   <= cfg_data;
				REG_MAX_DIST:    maxd_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	dsd_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (in_valid),
		.tag_poll_tx  (tag_poll_tx),
		.tag_resp_rx  (tag_resp_rx),
		.tag_final_tx (tag_final_tx),
		.own_poll_rx  (own_poll_rx),
		.own_resp_tx  (own_resp_tx),
		.own_final_rx (own_final_rx),
		.ctl          (ctl_c[0]),
		.rem_init     (rem_c[0]),
		.den          (den_c[0]),
		.num_low      (num_low)
	);

	// dividend is numerator << FRAC_BITS; its top TIME_BITS bits seed the remainder
	assign low_c[0] = {num_low, FRAC_BITS'(0)};

	for (genvar i = 0; i < QW; i++) begin : g_cell
		dsd_div_cell #(.RW(RW), .QW(QW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl_c[i]),
			.rem_in (rem_c[i]),
			.low_in (low_c[i]),
			.den_in (den_c[i]),
			.ctl_q  (ctl_c[i+1]),
			.rem_q  (rem_c[i+1]),
			.low_q  (low_c[i+1]),
			.den_q  (den_c[i+1])
		);
	end

	dsd_back #(.QW(QW), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.ctl_in          (ctl_c[QW]),
		.quot            (low_c[QW]),
		.mm_per_tick_q16 (mm_q),
		.max_distance_mm (maxd_q),
		.out_valid       (out_valid),
		.distance_mm     (distance_mm),
		.status          (status)
	);
endmodule

FILE: sv/dsd_checker.sv
`timescale 1ns / 1ps
`include "ds_twr_distance_defines.svh"
module dsd_checker import dsd_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [REG_W-1:0]    distance_mm,
	input logic [STATUS_W-1:0] status
);
	`DSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance_mm) && $stable(status))
	`DSD_ASSERT_NOW(a_reject_zero, out_valid && status != ST_OK, distance_mm == '0)
	`DSD_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready)
	`DSD_ASSERT_NOW(a_free_accepts, !out_valid, in_ready)
endmodule

bind ds_twr_distance dsd_checker u_dsd_checker (.*);

FILE: sim/dsd_checker.sv
`timescale 1ns / 1ps
module dsd_scoreboard import dsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [STAMP_W-1:0]   tag_poll_tx,
	input  logic [STAMP_W-1:0]   tag_resp_rx,
	input  logic [STAMP_W-1:0]   tag_final_tx,
	input  logic [STAMP_W-1:0]   own_poll_rx,
	input  logic [STAMP_W-1:0]   own_resp_tx,
	input  logic [STAMP_W-1:0]   own_final_rx,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [REG_W-1:0]     distance_mm,
	input  logic [STATUS_W-1:0]  status,
	output int                   errors,
	output int                   pending,
	output int                   n_ok,
	output int                   n_reject,
	output int                   n_range
);
	typedef struct packed {
		logic [REG_W-1:0]    dist_mm;
		logic [STATUS_W-1:0] st;
	} range_t;

	logic [REG_W-1:0] mm_per_tick;
	logic [REG_W-1:0] max_dist;
	range_t           ranges_due[$];

	// exact time of flight, truncated to 16 fraction bits, scaled and rounded
	function automatic range_t predict_range(
		input logic [31:0] ptx, rrx, ftx, prx, rtx, frx,
		input logic [REG_W-1:0] mm, maxd
	);
		logic [31:0]  ra, rb, da, db;
		logic [33:0]  den;
		logic [63:0]  pa, pb, q;
		logic [79:0]  num, quo;
		logic [87:0]  prod, lim;
		range_t       r;
		ra = rrx - ptx;
		rb = frx - rtx;
		da = ftx - rrx;
		db = rtx - prx;
		den = 34'(ra) + 34'(rb) + 34'(da) + 34'(db);
		pa = 64'(ra) * 64'(rb);
		pb = 64'(da) * 64'(db);
		r.dist_mm = '0;
		r.st = ST_REJECT;
		if (pa <= pb || den == 0)
			return r;
		num = 80'(pa - pb) << FRAC_BITS_DEF;
		quo = num / 80'(den);
		q = (quo[79:64] != 0) ? '1 : quo[63:0];
		prod = 88'(q) * 88'(mm);
		if (prod == 0)
			return r;
		lim = 88'(maxd) << (FRAC_BITS_DEF + SCALE_Q);
		if (prod >= lim) begin
			r.st = ST_RANGE;
			return r;
		end
		prod = prod + (88'(1) << (FRAC_BITS_DEF + SCALE_Q - 1));
		r.dist_mm = prod[FRAC_BITS_DEF+SCALE_Q +: REG_W];
		r.st = ST_OK;
		return r;
	endfunction

	assign pending = ranges_due.size();

	always @(posedge clk or negedge arst_n) begin
		range_t want;
		if (!arst_n) begin
			mm_per_tick <= MM_PER_TICK_RST;
			max_dist <= MAX_DIST_RST;
			ranges_due.delete();
			errors <= 0;
			n_ok <= 0;
			n_reject <= 0;
			n_range <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MM_PER_TICK)
					mm_per_tick <= cfg_data;
				else if (cfg_index == REG_MAX_DIST)
					max_dist <= cfg_data;
			end
			if (in_valid && in_ready)
				ranges_due.push_back(predict_range(tag_poll_tx, tag_resp_rx, tag_final_tx,
					own_poll_rx, own_resp_tx, own_final_rx, mm_per_tick, max_dist));
			if (out_valid && out_ready) begin
				if (ranges_due.size() == 0) begin
					if (errors < 10)
						$display("unexpected result beat: dist %0d status %0d",
							distance_mm, status);
					errors <= errors + 1;
				end else begin
					want = ranges_due.pop_front();
					case (want.st)
						ST_OK:     n_ok <= n_ok + 1;
						ST_RANGE:  n_range <= n_range + 1;
						default:   n_reject <= n_reject + 1;
					endcase
					if (want.dist_mm !== distance_mm || want.st !== status) begin
						if (errors < 10)
							$display("mismatch: dist exp %0d got %0d, status exp %0d got %0d",
								want.dist_mm, distance_mm, want.st, status);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;
	import dsd_pkg::*;

	// index past the register list, must be ignored by the block
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PIPE_LAT  = 60;
	localparam int RAND_ITEMS = 800;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [31:0] ptx, rrx, ftx, prx, rtx, frx;
	} exchange_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [STAMP_W-1:0]   tag_poll_tx, tag_resp_rx, tag_final_tx;
	logic [STAMP_W-1:0]   own_poll_rx, own_resp_tx, own_final_rx;
	logic                 out_valid;
	logic                 out_ready;
	logic [REG_W-1:0]     distance_mm;
	logic [STATUS_W-1:0]  status;

	int errors, pending, n_ok, n_reject, n_range;
	int sent;
	int cycles;
	bit held_off;

	ds_twr_distance dut (.*);

	dsd_scoreboard chk (.*);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// build one clean exchange: tof of t ticks, reply delays da and db
	function automatic exchange_t make_exchange(
		input logic [31:0] ptx, prx, t, da, db
	);
		exchange_t x;
		x.ptx = ptx;
		x.prx = prx;
		x.rtx = prx + db;
		x.rrx = ptx + 2 * t + db;
		x.ftx = x.rrx + da;
		x.frx = x.rtx + da + 2 * t;
		return x;
	endfunction

	function automatic exchange_t noise_exchange();
		exchange_t x;
		x.ptx = $urandom; x.rrx = $urandom; x.ftx = $urandom;
		x.prx = $urandom; x.rtx = $urandom; x.frx = $urandom;
		return x;
	endfunction

	// mostly well-formed exchanges with random content, some skewed or pure noise
	function automatic exchange_t random_exchange();
		exchange_t x;
		logic [31:0] t, da, db;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return noise_exchange();
		case ($urandom_range(0, 3))
			0: t = $urandom_range(0, 30);
			1: t = $urandom_range(0, 25000);
			2: t = $urandom_range(18000, 24000);
			default: t = $urandom_range(0, 32'h00FF_FFFF);
		endcase
		da = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 32'h3FFF_FFFF);
		db = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 32'h3FFF_FFFF);
		x = make_exchange($urandom, $urandom, t, da, db);
		// clock drift or a corrupted stamp
		if (pick < 35)
			x.rrx = x.rrx + $urandom_range(0, 64) - 32;
		else if (pick < 42)
			x.frx = x.frx - $urandom_range(0, 100000);
		return x;
	endfunction

	// one write, with cfg_we dropped again after it, so that writes never share a time step
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one input beat, with a random gap in front; valid stays high after a beat
	// and drops here only when a gap follows
	task automatic send_exchange(input exchange_t x, input bit gaps);
		int g;
		g = 0;
		if (gaps) begin
			g = $urandom_range(0, 99);
			if (g < 60)
				g = 0;
			else if (g < 95)
				g = $urandom_range(1, 3);
			else
				g = $urandom_range(20, 60);
		end
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		tag_poll_tx <= x.ptx;
		tag_resp_rx <= x.rrx;
		tag_final_tx <= x.ftx;
		own_poll_rx <= x.prx;
		own_resp_tx <= x.rtx;
		own_final_rx <= x.frx;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// wait for the pipe to drain before touching the registers
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	// receiver: random stalls, one long hold-off to back the pipe up
	initial begin
		out_ready = 1'b0;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && sent >= 150) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				held_off = 1'b1;
			end else if ($urandom_range(0, 199) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end else if ((sent / 100) % 3 == 1) begin
				// stretch with out_ready held high, apart from the rare random stalls
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) < 70);
			end
		end
	end

	initial begin
		logic [REG_W-1:0] mm_set [7];
		logic [REG_W-1:0] max_set [7];
		exchange_t x;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MM_PER_TICK;
		cfg_data = '0;
		in_valid = 1'b0;
		tag_poll_tx = '0; tag_resp_rx = '0; tag_final_tx = '0;
		own_poll_rx = '0; own_resp_tx = '0; own_final_rx = '0;
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset register values
		send_exchange('0, 1'b0);                                   // zero denominator
		send_exchange('1, 1'b0);                                   // all stamps equal
		x = make_exchange(32'hFFFF_FFF0, 32'hFFFF_FF00, 1000, 5000, 7000);
		send_exchange(x, 1'b0);                                    // wrapping stamps
		x = make_exchange(0, 0, 21319, 300000, 400000);
		send_exchange(x, 1'b0);                                    // just under the limit
		x = make_exchange(0, 0, 21320, 300000, 400000);
		send_exchange(x, 1'b0);                                    // still under the limit
		x = make_exchange(32'h1234_5678, 32'h8765_4321, 100, 1000, 1000);
		x.frx = x.frx - 5000;
		send_exchange(x, 1'b0);                                    // Rb wraps, numerator > 0
		x = make_exchange(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_exchange(x, 1'b0);                                    // large intervals
		x.ptx = 0; x.rrx = '1; x.ftx = 0; x.prx = 0; x.rtx = 0; x.frx = '1;
		send_exchange(x, 1'b0);                                    // widest ra and rb
		send_exchange(make_exchange(5, 7, 1, 0, 0), 1'b0);         // one tick, no reply delay
		send_exchange(make_exchange(5, 7, 0, 10, 20), 1'b0);       // zero time of flight
		drain();

		// ignored index, then register extremes
		cfg_write(REG_UNUSED, '1);
		cfg_write(REG_MAX_DIST, '0);                               // zero limit
		send_exchange(make_exchange(0, 0, 500, 1000, 2000), 1'b0);
		drain();
		cfg_write(REG_MM_PER_TICK, '0);                            // zero scale
		cfg_write(REG_MAX_DIST, '1);
		send_exchange(make_exchange(0, 0, 500, 1000, 2000), 1'b0);
		drain();
		cfg_write(REG_MM_PER_TICK, 24'd1);                         // tiny accepted distances
		send_exchange(make_exchange(0, 0, 1, 1000, 2000), 1'b0);
		send_exchange(make_exchange(0, 0, 16000, 1000, 2000), 1'b0);
		send_exchange(make_exchange(0, 0, 40000, 1000, 2000), 1'b0);
		drain();

		// random phases across several register settings
		mm_set  = '{MM_PER_TICK_RST, 24'hFF_FFFF, 24'd1, 24'd0, 24'd65536, 24'hFF_FFFF, 24'd0};
		max_set = '{MAX_DIST_RST, 24'hFF_FFFF, 24'hFF_FFFF, 24'd1, 24'd1, 24'd100, 24'd0};
		mm_set[6] = REG_W'($urandom_range(0, 24'hFF_FFFF));
		max_set[6] = REG_W'($urandom_range(1, 24'hFF_FFFF));
		for (int ph = 0; ph < 7; ph++) begin
			cfg_write(REG_MM_PER_TICK, mm_set[ph]);
			cfg_write(REG_MAX_DIST, max_set[ph]);
			repeat (RAND_ITEMS / 7)
				send_exchange(random_exchange(), 1'b1);
			drain();
		end

		$display("%0d exchanges over 7 register settings: %0d accepted, %0d rejected, %0d out of range",
			sent, n_ok, n_reject, n_range);
		$display("receiver hold-off done: %0d, %0d cycles", held_off, cycles);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
